// ===== hw/rtl/ipc_id_slot_table_top_assert.svh =====
// assertion macros for the ipc id slot table checker
`ifndef IPC_ID_SLOT_TABLE_TOP_ASSERT_SVH
`define IPC_ID_SLOT_TABLE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define IST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipc id slot table: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define IST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipc id slot table: assertion failed");

`endif

// ===== hw/rtl/ist_pkg.sv =====
// shared types and constants of the ipc id slot table
`default_nettype none

package ist_pkg;

	localparam int KEY_W      = 32;
	localparam int ID_W       = 32;
	localparam int HANDLE_W   = 32;
	localparam int CMD_W      = 2;
	localparam int SLOT_OUT_W = 5;
	localparam int IPC_ID_W   = 21;
	localparam int S_TDATA_W  = 96;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 64;
	localparam int M_TUSER_W  = 1;
	localparam int M_PAD_W    = M_TDATA_W - (SLOT_OUT_W + IPC_ID_W + HANDLE_W);

	// steps of the remainder unit
	localparam logic [1:0] MOD_QUO_STEP  = 2'd0;
	localparam logic [1:0] MOD_SUB_STEP  = 2'd1;
	localparam logic [1:0] MOD_LAST_STEP = 2'd2;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FAIL = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_FIND   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_GET    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SCAN_ZERO = 2'd0,
		SCAN_REM  = 2'd1,
		SCAN_HWM  = 2'd2
	} scan_src_t;

	typedef enum logic [2:0] {
		RES_FAIL = 3'd0,
		RES_SLOT = 3'd1,
		RES_REM  = 3'd2,
		RES_GET  = 3'd3,
		RES_ADD  = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic      load_in;
		logic      mod_step;
		logic      scan_init;
		scan_src_t scan_src;
		logic      scan_step;
		logic      scan_down;
		logic      issue;
		logic      clr_wr;
		logic      rm_wr;
		logic      add_wr;
		logic      hwm_rm;
		logic      hwm_clr;
		logic      res_load;
		res_kind_t res_kind;
		logic      out_load;
	} ist_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic id_neg;
		logic hwm_zero;
		logic mod_last;
		logic scan_hit;
		logic scan_last;
		logic clr_last;
		logic out_free;
	} ist_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ist_ctrl.sv =====
// sequencing state machine of the ipc id slot table
`default_nettype none

module ist_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire ist_pkg::ist_stat_t stat,
	output ist_pkg::ist_cmd_t       cmd
);
	import ist_pkg::*;

	typedef enum logic [9:0] {
		ST_CLEAR   = 10'b00_0000_0001,
		ST_IDLE    = 10'b00_0000_0010,
		ST_PREP    = 10'b00_0000_0100,
		ST_MOD     = 10'b00_0000_1000,
		ST_POSTMOD = 10'b00_0001_0000,
		ST_SHRINK  = 10'b00_0010_0000,
		ST_SCAN    = 10'b00_0100_0000,
		ST_ADD_WR  = 10'b00_1000_0000,
		ST_ADD_ID  = 10'b01_0000_0000,
		ST_DONE    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   s1_vld_q;
	logic   eval_hit, eval_last;

	assign eval_hit  = s1_vld_q && stat.scan_hit;
	assign eval_last = s1_vld_q && stat.scan_last;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr    = 1'b1;
				cmd.scan_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				unique case (stat.cmd)
					CMD_FIND: begin
						if (stat.hwm_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_FAIL;
							state_d      = ST_DONE;
						end else begin
							cmd.scan_init = 1'b1;
							cmd.scan_src  = SCAN_ZERO;
							state_d       = ST_SCAN;
						end
					end
					CMD_ADD: begin
						cmd.scan_init = 1'b1;
						cmd.scan_src  = SCAN_ZERO;
						state_d       = ST_SCAN;
					end
					CMD_REMOVE, CMD_GET: begin
						if (stat.id_neg) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_FAIL;
							state_d      = ST_DONE;
						end else begin
							state_d = ST_MOD;
						end
					end
				endcase
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = ST_POSTMOD;
				end
			end
			ST_POSTMOD: begin
				if (stat.cmd == CMD_GET) begin
					cmd.scan_init = 1'b1;
					cmd.scan_src  = SCAN_REM;
					state_d       = ST_SCAN;
				end else begin
					cmd.rm_wr = 1'b1;
					state_d   = ST_SHRINK;
				end
			end
			ST_SHRINK: begin
				if (stat.hwm_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_REM;
					state_d      = ST_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_src  = SCAN_HWM;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// keep reading ahead until an evaluated slot ends the scan
				cmd.issue     = !(eval_hit || eval_last);
				cmd.scan_step = !(eval_hit || eval_last);
				cmd.scan_down = (stat.cmd == CMD_REMOVE);
				if (eval_hit) begin
					unique case (stat.cmd)
						CMD_FIND: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_SLOT;
							state_d      = ST_DONE;
						end
						CMD_ADD: begin
							state_d = ST_ADD_WR;
						end
						CMD_REMOVE: begin
							cmd.hwm_rm   = 1'b1;
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_REM;
							state_d      = ST_DONE;
						end
						CMD_GET: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_GET;
							state_d      = ST_DONE;
						end
					endcase
				end else if (eval_last) begin
					cmd.res_load = 1'b1;
					state_d      = ST_DONE;
					if (stat.cmd == CMD_REMOVE) begin
						cmd.hwm_clr  = 1'b1;
						cmd.res_kind = RES_REM;
					end else begin
						cmd.res_kind = RES_FAIL;
					end
				end
			end
			ST_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = ST_ADD_ID;
			end
			ST_ADD_ID: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_ADD;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			s1_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			s1_vld_q <= cmd.issue;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ist_datapath.sv =====
// slot memories, remainder unit, scan pointer and result registers
`default_nettype none

module ist_datapath #(
	parameter int SLOTS    = 32,
	parameter int SEQ_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ist_pkg::ist_cmd_t                 cmd,
	input  wire logic [ist_pkg::S_TDATA_W-1:0]     s_tdata,
	input  wire logic [ist_pkg::S_TUSER_W-1:0]     s_tuser,
	output ist_pkg::ist_stat_t                     stat,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [ist_pkg::M_TDATA_W-1:0]          m_tdata,
	output logic [ist_pkg::M_TUSER_W-1:0]          m_tuser
);
	import ist_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int HWM_W = $clog2(SLOTS + 1);
	localparam int X_W   = ID_W - 1;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W:0]   SLOTS_EXT = (IDX_W + 1)'(SLOTS);
	localparam logic [X_W-1:0]   SLOTS_X   = X_W'(SLOTS);
	// floor(2^31 / SLOTS): quotient estimate is exact or one low
	localparam logic [X_W-1:0]   RECIP     = X_W'((64'd1 << X_W) / SLOTS);

	// input beat
	cmd_t                     cmd_q;
	logic signed [KEY_W-1:0]  key_q;
	logic [ID_W-1:0]          id_q;
	logic [HANDLE_W-1:0]      handle_q;

	// remainder by reciprocal multiply and one correction
	logic [1:0]         mod_cnt_q;
	logic [X_W-1:0]     quo_q;
	logic [2*X_W-1:0]   recip_prod;
	logic [X_W-1:0]     quo_mul, rem_diff;
	logic [IDX_W:0]     rem_wide_q;
	logic [IDX_W-1:0]   rem_q, rem_next;

	// scan pointer and high-water mark
	logic [IDX_W-1:0] scan_q;
	logic [HWM_W-1:0] hwm_q;
	logic [HWM_W-1:0] idx_plus1;

	// slot memories
	logic                    used_mem   [SLOTS];
	logic [KEY_W-1:0]        key_mem    [SLOTS];
	logic [HANDLE_W-1:0]     handle_mem [SLOTS];
	logic [SEQ_BITS-1:0]     seq_mem    [SLOTS];

	logic                    used_s1;
	logic [KEY_W-1:0]        key_s1;
	logic [HANDLE_W-1:0]     handle_s1;
	logic [SEQ_BITS-1:0]     seq_s1;
	logic [IDX_W-1:0]        idx_s1;

	logic [IDX_W-1:0]        wr_addr;
	logic                    used_we, used_wdata;
	logic                    seq_we;
	logic [SEQ_BITS-1:0]     seq_wdata, seq_inc;
	logic [SEQ_BITS-1:0]     seq_new_q;

	logic                    hit, last;

	// result staging and output beat
	logic                    res_status_d;
	logic [SLOT_OUT_W-1:0]   res_slot_d;
	logic [IPC_ID_W-1:0]     res_id_d;
	logic [HANDLE_W-1:0]     res_handle_d;
	logic                    res_status_q;
	logic [SLOT_OUT_W-1:0]   res_slot_q;
	logic [IPC_ID_W-1:0]     res_id_q;
	logic [HANDLE_W-1:0]     res_handle_q;
	logic [IPC_ID_W-1:0]     id_calc;
	logic [SLOT_OUT_W-1:0]   slot_s1_out, slot_rem_out;

	logic                    out_valid_q;
	logic                    out_status_q;
	logic [SLOT_OUT_W-1:0]   out_slot_q;
	logic [IPC_ID_W-1:0]     out_id_q;
	logic [HANDLE_W-1:0]     out_handle_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q    <= cmd_t'(s_tuser[CMD_W-1:0]);
			key_q    <= s_tdata[KEY_W-1:0];
			handle_q <= s_tdata[KEY_W+ID_W +: HANDLE_W];
		end
	end

	// id is non-negative here: quotient estimate, subtract, final correction
	assign recip_prod = id_q[X_W-1:0] * RECIP;
	assign quo_mul    = quo_q * SLOTS_X;
	assign rem_diff   = id_q[X_W-1:0] - quo_mul;
	assign rem_next   = (rem_wide_q >= SLOTS_EXT) ? IDX_W'(rem_wide_q - SLOTS_EXT)
		: IDX_W'(rem_wide_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q  <= '0;
			id_q       <= '0;
			quo_q      <= '0;
			rem_wide_q <= '0;
			rem_q      <= '0;
		end else if (cmd.load_in) begin
			mod_cnt_q <= '0;
			id_q      <= s_tdata[KEY_W +: ID_W];
		end else if (cmd.mod_step) begin
			mod_cnt_q <= mod_cnt_q + 2'd1;
			unique case (mod_cnt_q)
				MOD_QUO_STEP: quo_q      <= recip_prod[2*X_W-1:X_W];
				MOD_SUB_STEP: rem_wide_q <= rem_diff[IDX_W:0];
				default:      rem_q      <= rem_next;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.scan_init) begin
			unique case (cmd.scan_src)
				SCAN_ZERO: scan_q <= '0;
				SCAN_REM:  scan_q <= rem_q;
				SCAN_HWM:  scan_q <= IDX_W'(hwm_q - 1'b1);
				default:   scan_q <= '0;
			endcase
		end else if (cmd.scan_step) begin
			if (cmd.scan_down) begin
				if (scan_q != '0) begin
					scan_q <= scan_q - 1'b1;
				end
			end else if (scan_q != LAST_SLOT) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	assign idx_plus1 = HWM_W'(idx_s1) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hwm_q <= '0;
		end else if (cmd.hwm_clr) begin
			hwm_q <= '0;
		end else if (cmd.hwm_rm) begin
			hwm_q <= idx_plus1;
		end else if (cmd.add_wr && (idx_plus1 > hwm_q)) begin
			hwm_q <= idx_plus1;
		end
	end

	// write port
	assign seq_inc = seq_s1 + 1'b1;

	always_comb begin
		if (cmd.clr_wr) begin
			wr_addr = scan_q;
		end else if (cmd.rm_wr) begin
			wr_addr = rem_q;
		end else begin
			wr_addr = idx_s1;
		end
	end

	assign used_we    = cmd.clr_wr || cmd.rm_wr || cmd.add_wr;
	assign used_wdata = cmd.add_wr;
	assign seq_we     = cmd.clr_wr || cmd.add_wr;
	assign seq_wdata  = cmd.add_wr ? seq_inc : '0;

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[wr_addr] <= used_wdata;
		end
		if (seq_we) begin
			seq_mem[wr_addr] <= seq_wdata;
		end
		if (cmd.add_wr) begin
			key_mem[wr_addr]    <= key_q;
			handle_mem[wr_addr] <= handle_q;
			seq_new_q           <= seq_inc;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			used_s1   <= used_mem[scan_q];
			key_s1    <= key_mem[scan_q];
			handle_s1 <= handle_mem[scan_q];
			seq_s1    <= seq_mem[scan_q];
			idx_s1    <= scan_q;
		end
	end

	always_comb begin
		unique case (cmd_q)
			CMD_FIND: begin
				hit  = used_s1 && (key_s1 == key_q);
				last = (idx_plus1 == hwm_q);
			end
			CMD_ADD: begin
				hit  = !used_s1;
				last = (idx_s1 == LAST_SLOT);
			end
			CMD_REMOVE: begin
				hit  = used_s1;
				last = (idx_s1 == '0);
			end
			CMD_GET: begin
				hit  = used_s1;
				last = 1'b1;
			end
			default: begin
				hit  = 1'b0;
				last = 1'b1;
			end
		endcase
	end

	// result staging
	assign slot_s1_out  = SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, idx_s1});
	assign slot_rem_out = SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, rem_q});
	assign id_calc = IPC_ID_W'(seq_new_q) * IPC_ID_W'(SLOTS) + IPC_ID_W'(idx_s1);

	always_comb begin
		res_status_d = STAT_OK;
		res_slot_d   = '0;
		res_id_d     = '0;
		res_handle_d = '0;
		unique case (cmd.res_kind)
			RES_FAIL: res_status_d = STAT_FAIL;
			RES_SLOT: res_slot_d   = slot_s1_out;
			RES_REM:  res_slot_d   = slot_rem_out;
			RES_GET: begin
				res_slot_d   = slot_s1_out;
				res_handle_d = handle_s1;
			end
			RES_ADD: begin
				res_slot_d = slot_s1_out;
				res_id_d   = id_calc;
			end
			default: res_status_d = STAT_FAIL;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= res_status_d;
			res_slot_q   <= res_slot_d;
			res_id_q     <= res_id_d;
			res_handle_q <= res_handle_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_id_q     <= res_id_q;
			out_handle_q <= res_handle_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_handle_q, out_id_q, out_slot_q};
	assign m_tuser  = out_status_q;

	always_comb begin
		stat           = '0;
		stat.cmd       = cmd_q;
		stat.id_neg    = id_q[ID_W-1];
		stat.hwm_zero  = (hwm_q == '0);
		stat.mod_last  = (mod_cnt_q == MOD_LAST_STEP);
		stat.scan_hit  = hit;
		stat.scan_last = last;
		stat.clr_last  = (scan_q == LAST_SLOT);
		stat.out_free  = !out_valid_q || m_tready;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ipc_id_slot_table_top.sv =====
// top level of the ipc id slot table
//
// ipc id slot table: a table of SLOTS entries (used flag, key, object handle,
// SEQ_BITS-bit sequence) with a high-water mark, driven by one command beat
// at a time and answering each with exactly one result beat. All per-slot
// state lives in memories with one write port and one registered read port,
// so every search walks the slots at one per cycle. Find scans up from slot 0
// and misses at the high-water mark; a find on an empty table fails without
// a scan. Add takes the lowest free slot and fails when the table is full.
// Get reads the slot of the id; remove frees that slot and then shrinks the
// mark over the trailing free slots. Remove and get first reduce the id
// modulo SLOTS with a reciprocal multiply, a subtract and one correction; a
// negative id fails. Only one command is in flight, but the result register
// lets the next command beat be taken while the previous result still waits.
// After reset the block runs a clearing pass over the used flags and
// sequences of every slot before it takes its first command beat.
`default_nettype none

module ipc_id_slot_table_top #(
	parameter int SLOTS    = 32,
	parameter int SEQ_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command side
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// key [31:0], id [63:32], object_handle [95:64]
	input  wire logic [ist_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command [1:0]
	input  wire logic [ist_pkg::S_TUSER_W-1:0] s_axis_tuser,
	// result side
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// slot_index [4:0], ipc_id [25:5], object_handle_out [57:26], zeros [63:58]
	output logic [ist_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// status [0]
	output logic [ist_pkg::M_TUSER_W-1:0]      m_axis_tuser
);
	import ist_pkg::*;

	ist_cmd_t  cmd;
	ist_stat_t stat;

	// sequencer: walks each command through remainder, scan and write steps
	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot memories, scan pointer, high-water mark and result beat
	ist_datapath #(
		.SLOTS    (SLOTS),
		.SEQ_BITS (SEQ_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.stat     (stat),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ist_checker.sv =====
// port-level checker for the ipc id slot table and its bind
`default_nettype none

`include "ipc_id_slot_table_top_assert.svh"

module ist_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	// a result beat held back by the sink keeps its payload
	`IST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a failed command returns all-zero data
	`IST_ASSERT_SAME(a_fail_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0)

	// only add builds an id, and add never returns a handle
	`IST_ASSERT_SAME(a_id_no_handle, m_axis_tvalid && (m_axis_tdata[25:5] != 21'd0), m_axis_tdata[57:26] == 32'd0)

	// one command in flight: no command beat right after another
	`IST_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind ipc_id_slot_table_top ist_checker u_ist_checker (.*);

`default_nettype wire
